[hdl/mre_pkg.sv]
package mre_pkg;

  localparam int unsigned DataW = 32;

  // One input beat: a decoded R-type instruction with its operands.
  typedef struct packed {
    logic [5:0]       func;
    logic [4:0]       shift_amount;
    logic [4:0]       source_index;
    logic [4:0]       dest_index;
    logic [DataW-1:0] source_value;
    logic [DataW-1:0] target_value;
    logic [DataW-1:0] current_pc;
  } in_beat_t;

  // One output beat: writeback, next pc and status.
  typedef struct packed {
    logic [2:0]       status;
    logic             write_enable;
    logic [4:0]       write_index;
    logic [DataW-1:0] write_value;
    logic [DataW-1:0] next_pc;
  } out_beat_t;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StOverflow = 3'd1,
    StDivZero  = 3'd2,
    StReserved = 3'd3,
    StBadJump  = 3'd4
  } status_e;

  // Function codes.
  localparam logic [5:0] FnSll   = 6'h00;
  localparam logic [5:0] FnSrl   = 6'h02;
  localparam logic [5:0] FnSra   = 6'h03;
  localparam logic [5:0] FnSllv  = 6'h04;
  localparam logic [5:0] FnSrlv  = 6'h06;
  localparam logic [5:0] FnSrav  = 6'h07;
  localparam logic [5:0] FnJr    = 6'h08;
  localparam logic [5:0] FnJalr  = 6'h09;
  localparam logic [5:0] FnMfhi  = 6'h10;
  localparam logic [5:0] FnMthi  = 6'h11;
  localparam logic [5:0] FnMflo  = 6'h12;
  localparam logic [5:0] FnMtlo  = 6'h13;
  localparam logic [5:0] FnMult  = 6'h18;
  localparam logic [5:0] FnMultu = 6'h19;
  localparam logic [5:0] FnDiv   = 6'h1A;
  localparam logic [5:0] FnDivu  = 6'h1B;
  localparam logic [5:0] FnAdd   = 6'h20;
  localparam logic [5:0] FnAddu  = 6'h21;
  localparam logic [5:0] FnSub   = 6'h22;
  localparam logic [5:0] FnSubu  = 6'h23;
  localparam logic [5:0] FnAnd   = 6'h24;
  localparam logic [5:0] FnOr    = 6'h25;
  localparam logic [5:0] FnXor   = 6'h26;
  localparam logic [5:0] FnSlt   = 6'h2A;
  localparam logic [5:0] FnSltu  = 6'h2B;

  // Configuration register indexes and reset values.
  localparam logic             CfgJumpLow     = 1'b0;
  localparam logic             CfgJumpHigh    = 1'b1;
  localparam logic [DataW-1:0] JumpLowReset   = 32'h1000_0000;
  localparam logic [DataW-1:0] JumpHighReset  = 32'h1100_0000;

  // Operations of the bit-serial unit.
  typedef enum logic [2:0] {
    SopMul = 3'd0,
    SopDiv = 3'd1,
    SopSll = 3'd2,
    SopSrl = 3'd3,
    SopSra = 3'd4
  } sop_e;

  typedef struct packed {
    logic       start;
    sop_e       op;
    logic       is_signed;
    logic [4:0] amount;
  } ser_cmd_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] hi;
    logic [DataW-1:0] lo;
  } ser_rsp_t;

endpackage

[hdl/mre_serial_unit.sv]
module mre_serial_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mre_pkg::ser_cmd_t             cmd_i,
  input  logic [mre_pkg::DataW-1:0]     a_i,
  input  logic [mre_pkg::DataW-1:0]     b_i,
  output mre_pkg::ser_rsp_t             rsp_o
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_RUN  = 2'd1;
  localparam logic [1:0] U_FIX  = 2'd2;

  logic [1:0]  st_q, st_d;
  logic [4:0]  cnt_q, cnt_d;
  mre_pkg::sop_e op_q, op_d;
  logic        neg_x_q, neg_x_d;
  logic        neg_a_q, neg_a_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] sh_q, sh_d;
  logic [31:0] md_q, md_d;
  logic [31:0] hi_q, hi_d;
  logic [31:0] lo_q, lo_d;
  logic        done_q, done_d;

  logic [31:0] mag_a, mag_b;
  logic [32:0] sum;
  logic [33:0] diff;
  logic [63:0] prod_neg;

  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    op_d     = op_q;
    neg_x_d  = neg_x_q;
    neg_a_d  = neg_a_q;
    acc_d    = acc_q;
    sh_d     = sh_q;
    md_d     = md_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    done_d   = 1'b0;

    mag_a    = (cmd_i.is_signed && a_i[31]) ? (~a_i + 32'd1) : a_i;
    mag_b    = (cmd_i.is_signed && b_i[31]) ? (~b_i + 32'd1) : b_i;
    // One multiplier bit per cycle: add the multiplicand, then shift right.
    sum      = {1'b0, acc_q} + (sh_q[0] ? {1'b0, md_q} : 33'd0);
    // One quotient bit per cycle: trial subtract of the divisor.
    diff     = {1'b0, acc_q, sh_q[31]} - {2'b00, md_q};
    prod_neg = ~{acc_q, sh_q} + 64'd1;

    unique case (st_q)
      U_IDLE: begin
        if (cmd_i.start) begin
          op_d    = cmd_i.op;
          cnt_d   = 5'd31;
          neg_x_d = cmd_i.is_signed && (a_i[31] ^ b_i[31]);
          neg_a_d = cmd_i.is_signed && a_i[31];
          st_d    = U_RUN;
          unique case (cmd_i.op)
            mre_pkg::SopMul: begin
              acc_d = '0;
              sh_d  = mag_b;
              md_d  = mag_a;
            end
            mre_pkg::SopDiv: begin
              acc_d = '0;
              sh_d  = mag_a;
              md_d  = mag_b;
            end
            default: begin
              acc_d = b_i;
              cnt_d = cmd_i.amount - 5'd1;
              if (cmd_i.amount == 5'd0) begin
                st_d = U_FIX;
              end
            end
          endcase
        end
      end
      U_RUN: begin
        unique case (op_q)
          mre_pkg::SopMul: begin
            acc_d = sum[32:1];
            sh_d  = {sum[0], sh_q[31:1]};
          end
          mre_pkg::SopDiv: begin
            if (!diff[33]) begin
              acc_d = diff[31:0];
              sh_d  = {sh_q[30:0], 1'b1};
            end else begin
              acc_d = {acc_q[30:0], sh_q[31]};
              sh_d  = {sh_q[30:0], 1'b0};
            end
          end
          mre_pkg::SopSll: acc_d = {acc_q[30:0], 1'b0};
          mre_pkg::SopSrl: acc_d = {1'b0, acc_q[31:1]};
          default:         acc_d = {acc_q[31], acc_q[31:1]};
        endcase
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          st_d = U_FIX;
        end
      end
      U_FIX: begin
        unique case (op_q)
          mre_pkg::SopMul: begin
            {hi_d, lo_d} = neg_x_q ? prod_neg : {acc_q, sh_q};
          end
          mre_pkg::SopDiv: begin
            lo_d = neg_x_q ? (~sh_q + 32'd1) : sh_q;
            hi_d = neg_a_q ? (~acc_q + 32'd1) : acc_q;
          end
          default: lo_d = acc_q;
        endcase
        done_d = 1'b1;
        st_d   = U_IDLE;
      end
      default: st_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= U_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= mre_pkg::SopMul;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_x_q <= neg_x_d;
    neg_a_q <= neg_a_d;
    acc_q   <= acc_d;
    sh_q    <= sh_d;
    md_q    <= md_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
  end

  assign rsp_o = '{done: done_q, hi: hi_q, lo: lo_q};

endmodule

[hdl/mips_rtype_execute.sv]
// An accepted beat is latched and decoded; shifts, mult, multu, div and divu then run through
// the bit-serial unit, and the result moves to the output register before the next beat is taken.
// The block takes no new beat while one is in flight; the shared bit-serial unit retires one
// product, quotient or shift bit a cycle.
// Reset (asynchronous, active low) clears HI and LO, empties the block and the output
// register, and loads the jump limits with 0x10000000 and 0x11000000.
module mips_rtype_execute (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mre_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mre_pkg::out_beat_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [mre_pkg::DataW-1:0]     cfg_data_i
);

  // The block holds one instruction at a time. It is latched on accept, decoded in the
  // next cycle, sent through the serial unit if needed, and parked in a result register
  // until the output register is free. The output register is separate, so a new beat
  // can be taken while the previous result still waits downstream.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_RUN    = 2'd2;
  localparam logic [1:0] S_FIN    = 2'd3;

  logic [1:0]           state_q;
  mre_pkg::in_beat_t    item_q;
  mre_pkg::out_beat_t   res_q;
  mre_pkg::out_beat_t   out_q;
  logic                 out_valid_q;
  logic                 unit_hilo_q;
  logic [31:0]          hi_q, lo_q;
  logic [31:0]          jlo_q, jhi_q;

  logic                 in_accept;
  logic                 slot_free;

  // Decode results for the latched instruction.
  mre_pkg::status_e     status;
  logic                 wen;
  logic [31:0]          wval;
  logic [31:0]          npc;
  logic                 set_hi, set_lo;
  logic [31:0]          new_hi, new_lo;
  logic                 use_unit;
  mre_pkg::sop_e        sop;
  logic                 sgn;
  logic [4:0]           amt;
  logic [31:0]          a, b, pc;
  logic [31:0]          sum, dif;
  logic                 jump_ok;
  logic                 is_const_shift;

  mre_pkg::ser_cmd_t    ser_cmd;
  mre_pkg::ser_rsp_t    ser_rsp;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    a        = item_q.source_value;
    b        = item_q.target_value;
    pc       = item_q.current_pc;
    sum      = a + b;
    dif      = a - b;
    jump_ok  = (a >= jlo_q) && (a <= jhi_q);
    status   = mre_pkg::StOk;
    wen      = 1'b0;
    wval     = '0;
    npc      = pc + 32'd4;
    set_hi   = 1'b0;
    set_lo   = 1'b0;
    new_hi   = a;
    new_lo   = a;
    use_unit = 1'b0;
    sop      = mre_pkg::SopSll;
    sgn      = 1'b0;
    amt      = item_q.shift_amount;

    is_const_shift = (item_q.func == mre_pkg::FnSll) || (item_q.func == mre_pkg::FnSrl) ||
                     (item_q.func == mre_pkg::FnSra);

    // A nonzero shamt is only legal on the constant shifts.
    if (item_q.shift_amount != 5'd0 && !is_const_shift) begin
      status = mre_pkg::StReserved;
    end else begin
      unique case (item_q.func)
        mre_pkg::FnSll: begin
          wen = 1'b1; use_unit = 1'b1; sop = mre_pkg::SopSll;
        end
        mre_pkg::FnSrl: begin
          wen = 1'b1; use_unit = 1'b1; sop = mre_pkg::SopSrl;
        end
        mre_pkg::FnSra: begin
          wen = 1'b1; use_unit = 1'b1; sop = mre_pkg::SopSra;
        end
        mre_pkg::FnSllv: begin
          wen = 1'b1; use_unit = 1'b1; sop = mre_pkg::SopSll; amt = a[4:0];
        end
        mre_pkg::FnSrlv: begin
          wen = 1'b1; use_unit = 1'b1; sop = mre_pkg::SopSrl; amt = a[4:0];
        end
        mre_pkg::FnSrav: begin
          wen = 1'b1; use_unit = 1'b1; sop = mre_pkg::SopSra; amt = a[4:0];
        end
        mre_pkg::FnAdd: begin
          // Signed overflow: both operands share a sign that the sum does not.
          if ((a[31] == b[31]) && (sum[31] != a[31])) begin
            status = mre_pkg::StOverflow;
          end else begin
            wen = 1'b1; wval = sum;
          end
        end
        mre_pkg::FnSub: begin
          if ((a[31] != b[31]) && (dif[31] != a[31])) begin
            status = mre_pkg::StOverflow;
          end else begin
            wen = 1'b1; wval = dif;
          end
        end
        mre_pkg::FnAddu: begin wen = 1'b1; wval = sum; end
        mre_pkg::FnSubu: begin wen = 1'b1; wval = dif; end
        mre_pkg::FnAnd:  begin wen = 1'b1; wval = a & b; end
        mre_pkg::FnOr:   begin wen = 1'b1; wval = a | b; end
        mre_pkg::FnXor:  begin wen = 1'b1; wval = a ^ b; end
        mre_pkg::FnSlt: begin
          wen = 1'b1; wval = {31'd0, ($signed(a) < $signed(b))};
        end
        mre_pkg::FnSltu: begin
          wen = 1'b1; wval = {31'd0, (a < b)};
        end
        mre_pkg::FnMult: begin
          use_unit = 1'b1; sop = mre_pkg::SopMul; sgn = 1'b1;
        end
        mre_pkg::FnMultu: begin
          use_unit = 1'b1; sop = mre_pkg::SopMul;
        end
        mre_pkg::FnDiv: begin
          if (b == 32'd0) begin
            status = mre_pkg::StDivZero;
          end else begin
            use_unit = 1'b1; sop = mre_pkg::SopDiv; sgn = 1'b1;
          end
        end
        mre_pkg::FnDivu: begin
          if (b == 32'd0) begin
            status = mre_pkg::StDivZero;
          end else begin
            use_unit = 1'b1; sop = mre_pkg::SopDiv;
          end
        end
        mre_pkg::FnMfhi: begin wen = 1'b1; wval = hi_q; end
        mre_pkg::FnMflo: begin wen = 1'b1; wval = lo_q; end
        mre_pkg::FnMthi: set_hi = 1'b1;
        mre_pkg::FnMtlo: set_lo = 1'b1;
        mre_pkg::FnJr: begin
          if (!jump_ok) begin
            status = mre_pkg::StBadJump;
          end else begin
            npc = a;
          end
        end
        mre_pkg::FnJalr: begin
          // Linking into the register that holds the target is reserved.
          if (item_q.source_index == item_q.dest_index) begin
            status = mre_pkg::StReserved;
          end else if (!jump_ok) begin
            status = mre_pkg::StBadJump;
          end else begin
            wen = 1'b1; wval = pc + 32'd8; npc = a;
          end
        end
        default: status = mre_pkg::StReserved;
      endcase
    end

    // Any trap suppresses every write and leaves the pc on the faulting instruction.
    if (status != mre_pkg::StOk) begin
      wen      = 1'b0;
      wval     = '0;
      npc      = pc;
      set_hi   = 1'b0;
      set_lo   = 1'b0;
      use_unit = 1'b0;
    end
  end

  assign ser_cmd = '{start: (state_q == S_DECODE) && use_unit, op: sop, is_signed: sgn,
                     amount: amt};

  mre_serial_unit u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ser_cmd),
    .a_i    (a),
    .b_i    (b),
    .rsp_o  (ser_rsp)
  );

  // Control, architectural HI/LO and the configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hi_q        <= '0;
      lo_q        <= '0;
      jlo_q       <= mre_pkg::JumpLowReset;
      jhi_q       <= mre_pkg::JumpHighReset;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == mre_pkg::CfgJumpLow) begin
          jlo_q <= cfg_data_i;
        end else begin
          jhi_q <= cfg_data_i;
        end
      end

      // A finished result refills the output register in the cycle it drains.
      if (state_q == S_FIN && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (set_hi) begin
            hi_q <= new_hi;
          end
          if (set_lo) begin
            lo_q <= new_lo;
          end
          state_q <= use_unit ? S_RUN : S_FIN;
        end
        S_RUN: begin
          if (ser_rsp.done) begin
            // Multiply and divide land in HI/LO; shifts land in the writeback value.
            if (unit_hilo_q) begin
              hi_q <= ser_rsp.hi;
              lo_q <= ser_rsp.lo;
            end
            state_q <= S_FIN;
          end
        end
        default: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (state_q == S_DECODE) begin
      res_q.status       <= status;
      res_q.write_enable <= wen;
      res_q.write_index  <= wen ? item_q.dest_index : 5'd0;
      res_q.write_value  <= wval;
      res_q.next_pc      <= npc;
      unit_hilo_q        <= (sop == mre_pkg::SopMul) || (sop == mre_pkg::SopDiv);
    end
    if (state_q == S_RUN && ser_rsp.done && !unit_hilo_q) begin
      res_q.write_value <= ser_rsp.lo;
    end
    if (state_q == S_FIN && slot_free) begin
      out_q <= res_q;
    end
  end

endmodule

[hdl/mre_checker.sv]
module mre_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input mre_pkg::in_beat_t             in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input mre_pkg::out_beat_t            out_data_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic                          cfg_index_i,
  input logic [mre_pkg::DataW-1:0]     cfg_data_i
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // One instruction at a time: the block is busy right after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the previous instruction finished");

  // A trap writes nothing.
  a_trap_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != mre_pkg::StOk) |-> !out_data_o.write_enable)
    else $error("trap result carries a register write");

  // Without a write the index and value read as zero.
  a_idle_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_enable |->
      (out_data_o.write_index == 5'd0) && (out_data_o.write_value == 32'd0))
    else $error("write fields nonzero without a write");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= 3'(mre_pkg::StBadJump))
    else $error("undefined status code");

endmodule

bind mips_rtype_execute mre_checker u_checker (.*);
